### src/iwr_pkg.sv
// Shared types, codes and check helpers for the image window resolver.
package iwr_pkg;

  localparam int COORD_BITS   = 16;
  localparam int DIM_BITS     = 15;
  localparam int MASK_BITS    = 4;
  localparam int STATUS_BITS  = 4;
  localparam int CFG_IDX_BITS = 1;
  // headroom for 2*(a-b)+1 and first+count on the wider of coordinate and dimension
  localparam int CALC_BITS    = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] count_t;
  typedef logic        [DIM_BITS-1:0]   dim_t;
  typedef logic signed [CALC_BITS-1:0]  calc_t;
  typedef logic        [MASK_BITS-1:0]  mask_t;
  typedef logic        [STATUS_BITS-1:0] status_t;

  localparam calc_t CALC_ZERO = '0;
  localparam calc_t CALC_ONE  = calc_t'(1);

  // allowed combinations of given descriptions
  localparam mask_t CMB_BEGIN        = 4'd1;
  localparam mask_t CMB_CENTER       = 4'd2;
  localparam mask_t CMB_BEGIN_CENTER = 4'd3;
  localparam mask_t CMB_END          = 4'd4;
  localparam mask_t CMB_BEGIN_END    = 4'd5;
  localparam mask_t CMB_CENTER_END   = 4'd6;
  localparam mask_t CMB_SIZE         = 4'd8;
  localparam mask_t CMB_BEGIN_SIZE   = 4'd9;
  localparam mask_t CMB_CENTER_SIZE  = 4'd10;
  localparam mask_t CMB_END_SIZE     = 4'd12;

  localparam status_t ST_OK               = 4'd0;
  localparam status_t ST_BAD_BEGIN_LINE   = 4'd1;
  localparam status_t ST_BAD_BEGIN_SAMPLE = 4'd2;
  localparam status_t ST_BAD_CENTER_LINE  = 4'd3;
  localparam status_t ST_BAD_CENTER_SAMPLE = 4'd4;
  localparam status_t ST_BAD_END_LINE     = 4'd5;
  localparam status_t ST_BAD_END_SAMPLE   = 4'd6;
  localparam status_t ST_BAD_SIZE_LINES   = 4'd7;
  localparam status_t ST_BAD_SIZE_SAMPLES = 4'd8;
  localparam status_t ST_ORDER            = 4'd9;
  localparam status_t ST_NOFIT            = 4'd10;
  localparam status_t ST_COMBO            = 4'd11;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_LINES   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_SAMPLES = 1'd1;

  typedef struct packed {
    logic begin_bad;
    logic center_bad;
    logic end_bad;
    logic size_bad;
    logic begin_gt_center;
    logic begin_gt_end;
    logic center_gt_end;
  } axis_chk_t;

  typedef struct packed {
    calc_t first;
    calc_t count;
    logic  over_end;
    logic  before_start;
  } axis_res_t;

  function automatic calc_t coord_to_calc(coord_t v);
    return {{(CALC_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic calc_t dim_to_calc(dim_t n);
    return {{(CALC_BITS-DIM_BITS){1'b0}}, n};
  endfunction

  function automatic status_t point_status(logic line_bad, logic sample_bad,
                                           status_t line_code, status_t sample_code);
    status_t st;
    st = ST_OK;
    if (line_bad) st = line_code;
    else if (sample_bad) st = sample_code;
    return st;
  endfunction

  // status before the fit check; lines are checked ahead of samples
  function automatic status_t pre_status(mask_t mask, axis_chk_t l, axis_chk_t s);
    status_t st;
    st = ST_OK;
    unique case (mask)
      CMB_BEGIN: begin
        st = point_status(l.begin_bad, s.begin_bad, ST_BAD_BEGIN_LINE, ST_BAD_BEGIN_SAMPLE);
      end
      CMB_CENTER: begin
        st = point_status(l.center_bad, s.center_bad, ST_BAD_CENTER_LINE,
                          ST_BAD_CENTER_SAMPLE);
      end
      CMB_BEGIN_CENTER: begin
        st = point_status(l.begin_bad, s.begin_bad, ST_BAD_BEGIN_LINE, ST_BAD_BEGIN_SAMPLE);
        if (st == ST_OK)
          st = point_status(l.center_bad, s.center_bad, ST_BAD_CENTER_LINE,
                            ST_BAD_CENTER_SAMPLE);
        if (st == ST_OK && (l.begin_gt_center || s.begin_gt_center)) st = ST_ORDER;
      end
      CMB_END: begin
        st = point_status(l.end_bad, s.end_bad, ST_BAD_END_LINE, ST_BAD_END_SAMPLE);
      end
      CMB_BEGIN_END: begin
        st = point_status(l.begin_bad, s.begin_bad, ST_BAD_BEGIN_LINE, ST_BAD_BEGIN_SAMPLE);
        if (st == ST_OK)
          st = point_status(l.end_bad, s.end_bad, ST_BAD_END_LINE, ST_BAD_END_SAMPLE);
        if (st == ST_OK && (l.begin_gt_end || s.begin_gt_end)) st = ST_ORDER;
      end
      CMB_CENTER_END: begin
        st = point_status(l.center_bad, s.center_bad, ST_BAD_CENTER_LINE,
                          ST_BAD_CENTER_SAMPLE);
        if (st == ST_OK)
          st = point_status(l.end_bad, s.end_bad, ST_BAD_END_LINE, ST_BAD_END_SAMPLE);
        if (st == ST_OK && (l.center_gt_end || s.center_gt_end)) st = ST_ORDER;
      end
      CMB_SIZE: begin
        st = point_status(l.size_bad, s.size_bad, ST_BAD_SIZE_LINES, ST_BAD_SIZE_SAMPLES);
      end
      CMB_BEGIN_SIZE: begin
        st = point_status(l.begin_bad, s.begin_bad, ST_BAD_BEGIN_LINE, ST_BAD_BEGIN_SAMPLE);
        if (st == ST_OK)
          st = point_status(l.size_bad, s.size_bad, ST_BAD_SIZE_LINES, ST_BAD_SIZE_SAMPLES);
      end
      CMB_CENTER_SIZE: begin
        st = point_status(l.center_bad, s.center_bad, ST_BAD_CENTER_LINE,
                          ST_BAD_CENTER_SAMPLE);
        if (st == ST_OK)
          st = point_status(l.size_bad, s.size_bad, ST_BAD_SIZE_LINES, ST_BAD_SIZE_SAMPLES);
      end
      CMB_END_SIZE: begin
        st = point_status(l.end_bad, s.end_bad, ST_BAD_END_LINE, ST_BAD_END_SAMPLE);
        if (st == ST_OK)
          st = point_status(l.size_bad, s.size_bad, ST_BAD_SIZE_LINES, ST_BAD_SIZE_SAMPLES);
      end
      default: begin
        st = ST_COMBO;
      end
    endcase
    return st;
  endfunction

endpackage

### src/iwr_axis.sv
// One axis of the window datapath: range and order checks, window arithmetic, fit flags.
module iwr_axis (
  input  logic               clk,
  input  logic               adv1,
  input  logic               adv2,
  input  iwr_pkg::coord_t    begin_in,
  input  iwr_pkg::coord_t    center_in,
  input  iwr_pkg::coord_t    end_in,
  input  iwr_pkg::coord_t    size_in,
  input  iwr_pkg::dim_t      dim,
  input  iwr_pkg::mask_t     mask_s1,
  output iwr_pkg::axis_chk_t chk_s1,
  output iwr_pkg::axis_res_t res_s2
);

  iwr_pkg::calc_t     dim_x;
  iwr_pkg::calc_t     bx_in, cx_in, ex_in, zx_in;
  iwr_pkg::axis_chk_t chk_nxt;
  iwr_pkg::axis_chk_t chk_r;
  iwr_pkg::coord_t    begin_r, center_r, end_r, size_r;

  iwr_pkg::calc_t     bx, cx, ex, zx;
  iwr_pkg::calc_t     first_nxt, count_nxt;
  iwr_pkg::calc_t     first_r, count_r;
  iwr_pkg::calc_t     last_excl;

  assign dim_x = iwr_pkg::dim_to_calc(dim);
  assign bx_in = iwr_pkg::coord_to_calc(begin_in);
  assign cx_in = iwr_pkg::coord_to_calc(center_in);
  assign ex_in = iwr_pkg::coord_to_calc(end_in);
  assign zx_in = iwr_pkg::coord_to_calc(size_in);

  // stage 1: compares only
  always_comb begin
    chk_nxt.begin_bad       = (bx_in < iwr_pkg::CALC_ZERO) || (bx_in >= dim_x);
    chk_nxt.center_bad      = (cx_in < iwr_pkg::CALC_ZERO) || (cx_in >= dim_x);
    chk_nxt.end_bad         = (ex_in < iwr_pkg::CALC_ZERO) || (ex_in >= dim_x);
    chk_nxt.size_bad        = (zx_in < iwr_pkg::CALC_ONE)  || (zx_in >  dim_x);
    chk_nxt.begin_gt_center = (begin_in  > center_in);
    chk_nxt.begin_gt_end    = (begin_in  > end_in);
    chk_nxt.center_gt_end   = (center_in > end_in);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      chk_r    <= chk_nxt;
      begin_r  <= begin_in;
      center_r <= center_in;
      end_r    <= end_in;
      size_r   <= size_in;
    end
  end

  assign chk_s1 = chk_r;

  // stage 2: window arithmetic; only meaningful when the checks pass
  assign bx = iwr_pkg::coord_to_calc(begin_r);
  assign cx = iwr_pkg::coord_to_calc(center_r);
  assign ex = iwr_pkg::coord_to_calc(end_r);
  assign zx = iwr_pkg::coord_to_calc(size_r);

  always_comb begin
    first_nxt = iwr_pkg::CALC_ZERO;
    count_nxt = iwr_pkg::CALC_ZERO;
    unique case (mask_s1)
      iwr_pkg::CMB_BEGIN: begin
        first_nxt = bx;
        count_nxt = dim_x - bx;
      end
      iwr_pkg::CMB_CENTER: begin
        // window clipped symmetrically by the nearer image edge
        if (cx < (dim_x >>> 1)) begin
          first_nxt = iwr_pkg::CALC_ZERO;
          count_nxt = (cx <<< 1) + iwr_pkg::CALC_ONE;
        end else begin
          first_nxt = (cx <<< 1) - dim_x + iwr_pkg::CALC_ONE;
          count_nxt = ((dim_x - cx) <<< 1) - iwr_pkg::CALC_ONE;
        end
      end
      iwr_pkg::CMB_BEGIN_CENTER: begin
        first_nxt = bx;
        count_nxt = ((cx - bx) <<< 1) + iwr_pkg::CALC_ONE;
      end
      iwr_pkg::CMB_END: begin
        first_nxt = iwr_pkg::CALC_ZERO;
        count_nxt = ex + iwr_pkg::CALC_ONE;
      end
      iwr_pkg::CMB_BEGIN_END: begin
        first_nxt = bx;
        count_nxt = ex - bx + iwr_pkg::CALC_ONE;
      end
      iwr_pkg::CMB_CENTER_END: begin
        first_nxt = (cx <<< 1) - ex;
        count_nxt = ((ex - cx) <<< 1) + iwr_pkg::CALC_ONE;
      end
      iwr_pkg::CMB_SIZE, iwr_pkg::CMB_BEGIN_SIZE: begin
        first_nxt = bx;
        count_nxt = zx;
      end
      iwr_pkg::CMB_CENTER_SIZE: begin
        first_nxt = cx - (zx >>> 1);
        count_nxt = zx;
      end
      iwr_pkg::CMB_END_SIZE: begin
        first_nxt = ex - zx + iwr_pkg::CALC_ONE;
        count_nxt = zx;
      end
      default: begin
        first_nxt = iwr_pkg::CALC_ZERO;
        count_nxt = iwr_pkg::CALC_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      first_r <= first_nxt;
      count_r <= count_nxt;
    end
  end

  assign last_excl = first_r + count_r;

  always_comb begin
    res_s2.first        = first_r;
    res_s2.count        = count_r;
    res_s2.over_end     = (last_excl > dim_x);
    res_s2.before_start = (first_r < iwr_pkg::CALC_ZERO);
  end

endmodule

### src/image_window_resolver.sv
// Top level of the image window resolver: config registers, pipeline control, status.
// Takes one request beat per clock unless stalled and returns one result beat per
// request, in order, through three register stages: range and order compares, window
// arithmetic with the early status, then the fit check and zeroing of the window on
// error into the output register. A stalled output holds every stage; ready runs back
// through the stages so an empty stage always takes a beat. image_lines and
// image_samples reset to 1; the user writes them via cfg_wr_en while idle, not enforced.
module image_window_resolver (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                cfg_wr_en,
  input  logic [iwr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [iwr_pkg::DIM_BITS-1:0]        cfg_wr_data,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [iwr_pkg::MASK_BITS-1:0]       in_given_mask,
  input  logic signed [iwr_pkg::COORD_BITS-1:0] in_begin_line,
  input  logic signed [iwr_pkg::COORD_BITS-1:0] in_begin_sample,
  input  logic signed [iwr_pkg::COORD_BITS-1:0] in_center_line,
  input  logic signed [iwr_pkg::COORD_BITS-1:0] in_center_sample,
  input  logic signed [iwr_pkg::COORD_BITS-1:0] in_end_line,
  input  logic signed [iwr_pkg::COORD_BITS-1:0] in_end_sample,
  input  logic signed [iwr_pkg::COORD_BITS-1:0] in_size_lines,
  input  logic signed [iwr_pkg::COORD_BITS-1:0] in_size_samples,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [iwr_pkg::COORD_BITS-1:0] out_window_first_line,
  output logic signed [iwr_pkg::COORD_BITS-1:0] out_window_first_sample,
  output logic [iwr_pkg::COORD_BITS-1:0]      out_window_line_count,
  output logic [iwr_pkg::COORD_BITS-1:0]      out_window_sample_count,
  output logic [iwr_pkg::STATUS_BITS-1:0]     out_status
);

  iwr_pkg::dim_t      image_lines_r, image_samples_r;

  logic               adv1, adv2, adv3;
  logic               v1_r, v2_r, out_valid_r;
  iwr_pkg::mask_t     mask_s1_r, mask_s2_r;
  iwr_pkg::status_t   st_s2_nxt, st_s2_r;

  iwr_pkg::axis_chk_t chk_line, chk_samp;
  iwr_pkg::axis_res_t res_line, res_samp;

  logic               fit_hi, fit_lo, nofit;
  iwr_pkg::status_t   st_out_nxt, st_out_r;
  iwr_pkg::coord_t    first_line_nxt, first_samp_nxt, first_line_r, first_samp_r;
  iwr_pkg::count_t    cnt_line_nxt, cnt_samp_nxt, cnt_line_r, cnt_samp_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_lines_r   <= iwr_pkg::dim_t'(1);
      image_samples_r <= iwr_pkg::dim_t'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        iwr_pkg::CFG_IMAGE_LINES:   image_lines_r   <= cfg_wr_data;
        iwr_pkg::CFG_IMAGE_SAMPLES: image_samples_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when it is empty or its successor moves
  assign adv3     = !out_valid_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_valid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) out_valid_r <= v2_r;
    end
  end

  iwr_axis u_line (
    .clk       (clk),
    .adv1      (adv1),
    .adv2      (adv2),
    .begin_in  (in_begin_line),
    .center_in (in_center_line),
    .end_in    (in_end_line),
    .size_in   (in_size_lines),
    .dim       (image_lines_r),
    .mask_s1   (mask_s1_r),
    .chk_s1    (chk_line),
    .res_s2    (res_line)
  );

  iwr_axis u_samp (
    .clk       (clk),
    .adv1      (adv1),
    .adv2      (adv2),
    .begin_in  (in_begin_sample),
    .center_in (in_center_sample),
    .end_in    (in_end_sample),
    .size_in   (in_size_samples),
    .dim       (image_samples_r),
    .mask_s1   (mask_s1_r),
    .chk_s1    (chk_samp),
    .res_s2    (res_samp)
  );

  assign st_s2_nxt = iwr_pkg::pre_status(mask_s1_r, chk_line, chk_samp);

  always_ff @(posedge clk) begin
    if (adv1) mask_s1_r <= in_given_mask;
    if (adv2) begin
      mask_s2_r <= mask_s1_r;
      st_s2_r   <= st_s2_nxt;
    end
  end

  // stage 3: fit check, final status, zero the window on error
  always_comb begin
    fit_hi = (mask_s2_r == iwr_pkg::CMB_BEGIN_CENTER) ||
             (mask_s2_r == iwr_pkg::CMB_BEGIN_SIZE) ||
             (mask_s2_r == iwr_pkg::CMB_CENTER_SIZE);
    fit_lo = (mask_s2_r == iwr_pkg::CMB_CENTER_END) ||
             (mask_s2_r == iwr_pkg::CMB_END_SIZE) ||
             (mask_s2_r == iwr_pkg::CMB_CENTER_SIZE);
    nofit  = (fit_hi && (res_line.over_end || res_samp.over_end)) ||
             (fit_lo && (res_line.before_start || res_samp.before_start));

    priority if (st_s2_r != iwr_pkg::ST_OK) st_out_nxt = st_s2_r;
    else if (nofit)                         st_out_nxt = iwr_pkg::ST_NOFIT;
    else                                    st_out_nxt = iwr_pkg::ST_OK;

    if (st_out_nxt == iwr_pkg::ST_OK) begin
      first_line_nxt = res_line.first[iwr_pkg::COORD_BITS-1:0];
      first_samp_nxt = res_samp.first[iwr_pkg::COORD_BITS-1:0];
      cnt_line_nxt   = res_line.count[iwr_pkg::COORD_BITS-1:0];
      cnt_samp_nxt   = res_samp.count[iwr_pkg::COORD_BITS-1:0];
    end else begin
      first_line_nxt = '0;
      first_samp_nxt = '0;
      cnt_line_nxt   = '0;
      cnt_samp_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      st_out_r     <= st_out_nxt;
      first_line_r <= first_line_nxt;
      first_samp_r <= first_samp_nxt;
      cnt_line_r   <= cnt_line_nxt;
      cnt_samp_r   <= cnt_samp_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = st_out_r;
  assign out_window_first_line   = first_line_r;
  assign out_window_first_sample = first_samp_r;
  assign out_window_line_count   = cnt_line_r;
  assign out_window_sample_count = cnt_samp_r;

  // an accepted beat always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted beat not captured in stage 1");

  // a held first stage keeps its combination
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !adv1) |=> (v1_r && $stable(mask_s1_r)))
    else $error("stage 1 beat lost or changed under stall");

  // a middle beat survives a blocked output
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && out_valid_r && !out_ready) |=> (v2_r && $stable(st_s2_r)))
    else $error("stage 2 beat lost or changed under stall");

  // any error status carries an all-zero window
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != iwr_pkg::ST_OK)) |->
      ((out_window_first_line == '0) && (out_window_first_sample == '0) &&
       (out_window_line_count == '0) && (out_window_sample_count == '0)))
    else $error("window not zeroed on error status");

endmodule
